// ===== src/lobm_pkg.sv =====
// Shared codes and control types of the limit order book matcher.
`default_nettype none
package lobm_pkg;

	// Request actions, carried in s_tuser
	localparam logic [1:0] ACT_LIMIT  = 2'd0;
	localparam logic [1:0] ACT_MARKET = 2'd1;
	localparam logic [1:0] ACT_CANCEL = 2'd2;
	localparam logic [1:0] ACT_MODIFY = 2'd3;

	// Final status codes
	localparam logic [1:0] ST_OK        = 2'd0;
	localparam logic [1:0] ST_NOT_FOUND = 2'd1;
	localparam logic [1:0] ST_REJECT    = 2'd2;
	localparam logic [1:0] ST_PARTIAL   = 2'd3;

	// Result kinds, carried in m_tuser
	localparam logic KIND_TRADE  = 1'b0;
	localparam logic KIND_STATUS = 1'b1;

	// Operation broadcast to the slot cells
	typedef enum logic [2:0] {
		CMD_NONE,
		CMD_PLACE,
		CMD_KILL,
		CMD_SETQ,
		CMD_SETQS,
		CMD_TAKE
	} cmd_op_t;

	typedef struct packed {
		cmd_op_t     op;
		logic        tk2_en;
		logic [15:0] qty;
	} cmd_t;

	// Sequencer states
	typedef enum logic [1:0] {
		S_IDLE,
		S_SWEEP,
		S_DECIDE
	} state_t;

	// What the sweep just finished was run for
	typedef enum logic [1:0] {
		PH_LOOKUP,
		PH_MATCH,
		PH_MARKET
	} phase_t;

endpackage
`default_nettype wire

// ===== src/lobm_cell.sv =====
// One resting order slot with its stage of the best-price search chain.
`default_nettype none
module lobm_cell #(
	parameter int unsigned MAX_ORDERS = 32,
	parameter int unsigned PRICE_BITS = 8,
	parameter int unsigned ID_BITS = 16,
	parameter int unsigned IDX = 0,
	localparam int unsigned IW = (MAX_ORDERS > 1) ? $clog2(MAX_ORDERS) : 1,
	localparam int unsigned CW = 2 * (1 + IW + PRICE_BITS + 32 + 16 + ID_BITS)
		+ (1 + IW + 1 + PRICE_BITS + 16) + (1 + IW)
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  lobm_pkg::cmd_t        cmd,
	input  logic [IW-1:0]         cmd_idx,
	input  logic [IW-1:0]         tk2_idx,
	input  logic                  wr_side,
	input  logic [PRICE_BITS-1:0] wr_price,
	input  logic [ID_BITS-1:0]    wr_id,
	input  logic [31:0]           stamp,
	input  logic [ID_BITS-1:0]    find_id,
	input  logic [CW-1:0]         carry_i,
	output logic [CW-1:0]         carry_o
);
	import lobm_pkg::*;

	typedef struct packed {
		logic                  vld;
		logic [IW-1:0]         idx;
		logic [PRICE_BITS-1:0] price;
		logic [31:0]           age;
		logic [15:0]           qty;
		logic [ID_BITS-1:0]    id;
	} best_t;

	typedef struct packed {
		logic                  hit;
		logic [IW-1:0]         idx;
		logic                  side;
		logic [PRICE_BITS-1:0] price;
		logic [15:0]           qty;
	} find_t;

	typedef struct packed {
		logic          vld;
		logic [IW-1:0] idx;
	} free_t;

	typedef struct packed {
		best_t bid;
		best_t ask;
		find_t fnd;
		free_t fre;
	} carry_t;

	localparam logic [IW-1:0] MY = IW'(IDX);

	logic                  vld_q;
	logic                  side_q;
	logic [PRICE_BITS-1:0] price_q;
	logic [ID_BITS-1:0]    id_q;
	logic [15:0]           qty_q;
	logic [31:0]           seq_q;
	logic [15:0]           qty_dec;
	logic                  sel;
	logic                  sel2;
	logic [31:0]           age;
	carry_t                c_in;
	carry_t                c_nx;
	carry_t                carry_q;
	best_t                 mine;
	logic                  bid_take;
	logic                  ask_take;

	assign sel     = (cmd_idx == MY);
	assign sel2    = cmd.tk2_en && (tk2_idx == MY);
	assign qty_dec = qty_q - cmd.qty;

	// Track slot occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else begin
			case (cmd.op)
				CMD_PLACE: begin
					if (sel) vld_q <= 1'b1;
				end
				CMD_KILL: begin
					if (sel) vld_q <= 1'b0;
				end
				CMD_TAKE: begin
					if ((sel || sel2) && (qty_dec == 16'd0)) vld_q <= 1'b0;
				end
				default: begin
				end
			endcase
		end
	end

	// Update slot contents
	always_ff @(posedge clk) begin
		case (cmd.op)
			CMD_PLACE: begin
				if (sel) begin
					side_q  <= wr_side;
					price_q <= wr_price;
					id_q    <= wr_id;
					qty_q   <= cmd.qty;
					seq_q   <= stamp;
				end
			end
			CMD_SETQ: begin
				if (sel) qty_q <= cmd.qty;
			end
			CMD_SETQS: begin
				if (sel) begin
					qty_q <= cmd.qty;
					seq_q <= stamp;
				end
			end
			CMD_TAKE: begin
				if (sel || sel2) qty_q <= qty_dec;
			end
			default: begin
			end
		endcase
	end

	// Fold this slot into the running best, lookup and free search
	always_comb begin
		c_in       = carry_t'(carry_i);
		age        = stamp - seq_q;
		mine.vld   = 1'b1;
		mine.idx   = MY;
		mine.price = price_q;
		mine.age   = age;
		mine.qty   = qty_q;
		mine.id    = id_q;
		bid_take = vld_q && !side_q && (!c_in.bid.vld || (price_q > c_in.bid.price)
			|| ((price_q == c_in.bid.price) && (age > c_in.bid.age)));
		ask_take = vld_q && side_q && (!c_in.ask.vld || (price_q < c_in.ask.price)
			|| ((price_q == c_in.ask.price) && (age > c_in.ask.age)));
		c_nx     = c_in;
		if (bid_take) c_nx.bid = mine;
		if (ask_take) c_nx.ask = mine;
		if (!c_in.fnd.hit && vld_q && (id_q == find_id)) begin
			c_nx.fnd.hit   = 1'b1;
			c_nx.fnd.idx   = MY;
			c_nx.fnd.side  = side_q;
			c_nx.fnd.price = price_q;
			c_nx.fnd.qty   = qty_q;
		end
		if (!c_in.fre.vld && !vld_q) begin
			c_nx.fre.vld = 1'b1;
			c_nx.fre.idx = MY;
		end
	end

	// Hand the search on to the next cell
	always_ff @(posedge clk) begin
		carry_q <= c_nx;
	end

	assign carry_o = carry_q;

endmodule
`default_nettype wire

// ===== src/limit_order_book_matcher.sv =====
// Top level: request sequencer, output register and the row of slot cells.
// Each book search walks the row of registered slot cells, then acts in S_DECIDE, where a
// stalled output register can hold it. A request answered at lookup
// takes one search; any other request takes two searches plus one per trade.
// Throughput: one request in work at a time; the last result may wait in the output register.
// Reset clears all slot valid bits, the arrival counter and the sequencer at once.
`default_nettype none
module limit_order_book_matcher #(
	parameter int unsigned MAX_ORDERS = 32,
	parameter int unsigned PRICE_BITS = 8,
	parameter int unsigned ID_BITS = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	// order_id[15:0], side[16], price[24:17], quantity[40:25], zero pad
	input  logic [47:0] s_tdata,
	// action[1:0]
	input  logic [1:0]  s_tuser,
	output logic        m_tvalid,
	input  logic        m_tready,
	// buy_id[15:0], sell_id[31:16], trade_price[39:32], trade_qty[55:40],
	// status[57:56], unfilled_qty[73:58], zero pad
	output logic [79:0] m_tdata,
	// kind[0]
	output logic        m_tuser,
	output logic        m_tlast
);
	import lobm_pkg::*;

	localparam int unsigned IW = (MAX_ORDERS > 1) ? $clog2(MAX_ORDERS) : 1;
	localparam int unsigned CW = 2 * (1 + IW + PRICE_BITS + 32 + 16 + ID_BITS)
		+ (1 + IW + 1 + PRICE_BITS + 16) + (1 + IW);

	typedef struct packed {
		logic                  vld;
		logic [IW-1:0]         idx;
		logic [PRICE_BITS-1:0] price;
		logic [31:0]           age;
		logic [15:0]           qty;
		logic [ID_BITS-1:0]    id;
	} best_t;

	typedef struct packed {
		logic                  hit;
		logic [IW-1:0]         idx;
		logic                  side;
		logic [PRICE_BITS-1:0] price;
		logic [15:0]           qty;
	} find_t;

	typedef struct packed {
		logic          vld;
		logic [IW-1:0] idx;
	} free_t;

	typedef struct packed {
		best_t bid;
		best_t ask;
		find_t fnd;
		free_t fre;
	} carry_t;

	state_t                state_q, state_nx;
	phase_t                phase_q, phase_nx;
	logic [IW-1:0]         cnt_q;
	logic [1:0]            rq_action_q;
	logic [ID_BITS-1:0]    rq_id_q;
	logic                  rq_side_q;
	logic [PRICE_BITS-1:0] rq_price_q;
	logic [15:0]           rq_qty_q;
	logic [31:0]           counter_q;
	logic                  out_vld_q;
	logic [79:0]           out_data_q;
	logic                  out_kind_q;

	logic [CW-1:0]         chain [0:MAX_ORDERS];
	carry_t                fin;
	best_t                 rest;
	logic [15:0]           mq;
	logic [15:0]           tq;

	cmd_t                  dc_cmd, cmd;
	logic [IW-1:0]         cmd_idx, tk2_idx;
	logic                  wr_side;
	logic [PRICE_BITS-1:0] wr_price;
	logic                  emit, go_final, cnt_inc, fire, out_free, accept;
	logic                  em_kind;
	logic [ID_BITS-1:0]    em_buy, em_sell;
	logic [PRICE_BITS-1:0] em_price;
	logic [15:0]           em_tq, em_unf, qty_nx;
	logic [1:0]            em_status;
	logic [31:0]           buy32, sell32;
	logic [15:0]           price16;
	logic [31:0]           in_id32;
	logic [15:0]           in_price16;

	assign accept   = s_tvalid && s_tready;
	assign s_tready = (state_q == S_IDLE);
	assign out_free = !out_vld_q || m_tready;
	assign fire     = (state_q == S_DECIDE) && (!emit || out_free);
	assign fin      = carry_t'(chain[MAX_ORDERS]);
	assign rest     = rq_side_q ? fin.bid : fin.ask;
	assign mq       = (fin.bid.qty < fin.ask.qty) ? fin.bid.qty : fin.ask.qty;
	assign tq       = (rq_qty_q < rest.qty) ? rq_qty_q : rest.qty;

	// Row of slot cells
	assign chain[0] = '0;
	for (genvar k = 0; k < MAX_ORDERS; k++) begin : g_cell
		lobm_cell #(
			.MAX_ORDERS(MAX_ORDERS),
			.PRICE_BITS(PRICE_BITS),
			.ID_BITS(ID_BITS),
			.IDX(k)
		) u_cell (
			.clk(clk),
			.arst_n(arst_n),
			.cmd(cmd),
			.cmd_idx(cmd_idx),
			.tk2_idx(tk2_idx),
			.wr_side(wr_side),
			.wr_price(wr_price),
			.wr_id(rq_id_q),
			.stamp(counter_q),
			.find_id(rq_id_q),
			.carry_i(chain[k]),
			.carry_o(chain[k+1])
		);
	end

	// Decide what the finished search leads to
	always_comb begin
		dc_cmd    = '{op: CMD_NONE, tk2_en: 1'b0, qty: rq_qty_q};
		cmd_idx   = fin.fnd.idx;
		tk2_idx   = fin.bid.idx;
		wr_side   = rq_side_q;
		wr_price  = rq_price_q;
		emit      = 1'b0;
		go_final  = 1'b0;
		cnt_inc   = 1'b0;
		phase_nx  = PH_MATCH;
		qty_nx    = rq_qty_q;
		em_kind   = KIND_TRADE;
		em_buy    = '0;
		em_sell   = '0;
		em_price  = '0;
		em_tq     = '0;
		em_status = ST_OK;
		em_unf    = '0;
		case (phase_q)
			PH_LOOKUP: begin
				case (rq_action_q)
					ACT_LIMIT: begin
						if (fin.fnd.hit) begin
							go_final  = 1'b1;
							em_status = ST_REJECT;
						end else if (rq_qty_q == 16'd0) begin
							go_final = 1'b1;
						end else if (!fin.fre.vld) begin
							go_final  = 1'b1;
							em_status = ST_REJECT;
						end else begin
							dc_cmd.op = CMD_PLACE;
							cmd_idx   = fin.fre.idx;
							cnt_inc   = 1'b1;
						end
					end
					ACT_MARKET: begin
						cnt_inc  = 1'b1;
						phase_nx = PH_MARKET;
					end
					ACT_CANCEL: begin
						go_final = 1'b1;
						if (fin.fnd.hit) dc_cmd.op = CMD_KILL;
						else em_status = ST_NOT_FOUND;
					end
					default: begin
						if (!fin.fnd.hit) begin
							go_final  = 1'b1;
							em_status = ST_NOT_FOUND;
						end else if (rq_qty_q == 16'd0) begin
							go_final  = 1'b1;
							dc_cmd.op = CMD_KILL;
						end else if (fin.fnd.price != rq_price_q) begin
							dc_cmd.op = CMD_PLACE;
							wr_side   = fin.fnd.side;
							cnt_inc   = 1'b1;
						end else if (rq_qty_q > fin.fnd.qty) begin
							dc_cmd.op = CMD_SETQS;
							cnt_inc   = 1'b1;
						end else begin
							dc_cmd.op = CMD_SETQ;
						end
					end
				endcase
			end
			PH_MATCH: begin
				if (fin.bid.vld && fin.ask.vld && (fin.bid.price >= fin.ask.price)) begin
					dc_cmd.op     = CMD_TAKE;
					dc_cmd.tk2_en = 1'b1;
					dc_cmd.qty    = mq;
					cmd_idx       = fin.ask.idx;
					tk2_idx       = fin.bid.idx;
					em_buy        = fin.bid.id;
					em_sell       = fin.ask.id;
					em_price      = fin.ask.price;
					em_tq         = mq;
				end else begin
					go_final = 1'b1;
				end
			end
			default: begin
				phase_nx = PH_MARKET;
				if (rq_qty_q == 16'd0) begin
					go_final = 1'b1;
				end else if (!rest.vld) begin
					go_final  = 1'b1;
					em_status = ST_PARTIAL;
					em_unf    = rq_qty_q;
				end else begin
					dc_cmd.op  = CMD_TAKE;
					dc_cmd.qty = tq;
					cmd_idx    = rest.idx;
					qty_nx     = rq_qty_q - tq;
					em_buy     = rq_side_q ? rest.id : rq_id_q;
					em_sell    = rq_side_q ? rq_id_q : rest.id;
					em_price   = rest.price;
					em_tq      = tq;
				end
			end
		endcase
		if (go_final) begin
			em_kind = KIND_STATUS;
		end
		emit = go_final || (dc_cmd.op == CMD_TAKE);
	end

	// Apply the cell operation only when the step goes ahead
	always_comb begin
		cmd = dc_cmd;
		if (!fire) cmd.op = CMD_NONE;
	end

	// Next state
	always_comb begin
		state_nx = state_q;
		case (state_q)
			S_IDLE: begin
				if (accept) state_nx = S_SWEEP;
			end
			S_SWEEP: begin
				if (cnt_q == IW'(MAX_ORDERS - 1)) state_nx = S_DECIDE;
			end
			S_DECIDE: begin
				if (fire) state_nx = go_final ? S_IDLE : S_SWEEP;
			end
			default: state_nx = S_IDLE;
		endcase
	end

	// Sequencer registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			phase_q   <= PH_LOOKUP;
			cnt_q     <= '0;
			counter_q <= '0;
		end else begin
			state_q <= state_nx;
			if (state_q == S_SWEEP) cnt_q <= cnt_q + IW'(1);
			else cnt_q <= '0;
			if (accept) phase_q <= PH_LOOKUP;
			else if (fire) phase_q <= phase_nx;
			if (fire && cnt_inc) counter_q <= counter_q + 32'd1;
		end
	end

	// Capture the request beat
	assign in_id32    = {16'd0, s_tdata[15:0]};
	assign in_price16 = {8'd0, s_tdata[24:17]};

	always_ff @(posedge clk) begin
		if (accept) begin
			rq_action_q <= s_tuser;
			rq_id_q     <= in_id32[ID_BITS-1:0];
			rq_side_q   <= s_tdata[16];
			rq_price_q  <= in_price16[PRICE_BITS-1:0];
			rq_qty_q    <= s_tdata[40:25];
		end else if (fire) begin
			rq_qty_q <= qty_nx;
		end
	end

	// Output register
	assign buy32   = 32'(em_buy);
	assign sell32  = 32'(em_sell);
	assign price16 = 16'(em_price);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (fire && emit) begin
			out_vld_q <= 1'b1;
		end else if (m_tready) begin
			out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire && emit) begin
			out_data_q <= {6'd0, em_unf, em_status, em_tq, price16[7:0],
				sell32[15:0], buy32[15:0]};
			out_kind_q <= em_kind;
		end
	end

	assign m_tvalid = out_vld_q;
	assign m_tdata  = out_data_q;
	assign m_tuser  = out_kind_q;
	assign m_tlast  = out_kind_q;

endmodule
`default_nettype wire

// ===== src/lobm_checker.sv =====
// Port-level checks of the limit order book matcher, bound to its top level.
`default_nettype none
module lobm_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        s_tvalid,
	input wire logic        s_tready,
	input wire logic [47:0] s_tdata,
	input wire logic [1:0]  s_tuser,
	input wire logic        m_tvalid,
	input wire logic        m_tready,
	input wire logic [79:0] m_tdata,
	input wire logic        m_tuser,
	input wire logic        m_tlast
);
	import lobm_pkg::*;

	// Only the status beat closes a request
	a_last_is_status: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tlast == (m_tuser == KIND_STATUS)))
		else $error("last flag does not match result kind");

	// Trade beats carry no status and no dropped rest
	a_trade_clean: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && (m_tuser == KIND_TRADE)) |-> (m_tdata[73:56] == 18'd0))
		else $error("trade beat carries status fields");

	// One request in work: ready drops after a request beat
	a_one_request: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |=> !s_tready)
		else $error("second request taken while one is in work");

	// Stalled result beat holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tuser)))
		else $error("stalled result beat changed");

endmodule

bind limit_order_book_matcher lobm_checker u_lobm_checker (.*);
`default_nettype wire

// ===== sim/lobm_checker.sv =====
// Scoreboard for the order book matcher: mirrors the book, predicts result beats, compares.
`default_nettype none
module lobm_scoreboard #(
	parameter int unsigned SLOTS = 32
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	input  wire logic        s_tready,
	input  wire logic [47:0] s_tdata,
	input  wire logic [1:0]  s_tuser,
	input  wire logic        m_tvalid,
	input  wire logic        m_tready,
	input  wire logic [79:0] m_tdata,
	input  wire logic        m_tuser,
	input  wire logic        m_tlast,
	output int               errors,
	output int               pending
);
	import lobm_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		logic        kind;
		logic [15:0] buy_id;
		logic [15:0] sell_id;
		logic [7:0]  px;
		logic [15:0] qty;
		logic [1:0]  status;
		logic [15:0] unfilled;
		logic        last;
	} fill_t;

	// Mirror of the resting book
	logic        live [SLOTS];
	logic        sd   [SLOTS];
	logic [7:0]  lvl  [SLOTS];
	logic [15:0] oid  [SLOTS];
	logic [15:0] rest [SLOTS];
	logic [31:0] stamp[SLOTS];
	logic [31:0] arrivals;

	// Ring of predicted beats
	fill_t due_q [64];
	int    wr_idx;
	int    rd_idx;

	function automatic int find_order(logic [15:0] id);
		for (int i = 0; i < SLOTS; i++)
			if (live[i] && oid[i] == id) return i;
		return -1;
	endfunction

	function automatic int top_of(logic s);
		int b;
		b = -1;
		for (int i = 0; i < SLOTS; i++) begin
			if (!live[i] || sd[i] != s) continue;
			if (b < 0) begin
				b = i;
				continue;
			end
			if (lvl[i] != lvl[b]) begin
				if (s == 1'b0 ? lvl[i] > lvl[b] : lvl[i] < lvl[b]) b = i;
			end else if (32'(arrivals - stamp[i]) > 32'(arrivals - stamp[b])) begin
				b = i;
			end
		end
		return b;
	endfunction

	task automatic enqueue(fill_t f);
		due_q[wr_idx & 63] = f;
		wr_idx++;
	endtask

	task automatic post_fill(logic [15:0] b, logic [15:0] s, logic [7:0] p, logic [15:0] q);
		fill_t f;
		f = '0;
		f.buy_id = b;
		f.sell_id = s;
		f.px = p;
		f.qty = q;
		enqueue(f);
	endtask

	task automatic post_status(logic [1:0] st, logic [15:0] unf);
		fill_t f;
		f = '0;
		f.kind = KIND_STATUS;
		f.status = st;
		f.unfilled = unf;
		f.last = 1'b1;
		enqueue(f);
	endtask

	task automatic reduce(int i, logic [15:0] q);
		rest[i] -= q;
		if (rest[i] == 0) live[i] = 1'b0;
	endtask

	task automatic rest_order(int i, logic s, logic [7:0] p, logic [15:0] id, logic [15:0] q);
		live[i] = 1'b1;
		sd[i] = s;
		lvl[i] = p;
		oid[i] = id;
		rest[i] = q;
		stamp[i] = arrivals;
		arrivals++;
	endtask

	task automatic cross_book();
		int b, a;
		logic [15:0] q;
		forever begin
			b = top_of(1'b0);
			a = top_of(1'b1);
			if (b < 0 || a < 0 || lvl[b] < lvl[a]) break;
			q = rest[b] < rest[a] ? rest[b] : rest[a];
			post_fill(oid[b], oid[a], lvl[a], q);
			reduce(b, q);
			reduce(a, q);
		end
	endtask

	task automatic apply_request(logic [1:0] act, logic [47:0] d);
		logic [15:0] id, q, left, t;
		logic        s;
		logic [7:0]  p;
		int          i, r;
		id = d[15:0];
		s = d[16];
		p = d[24:17];
		q = d[40:25];
		case (act)
			ACT_LIMIT: begin
				if (find_order(id) >= 0) post_status(ST_REJECT, 16'd0);
				else if (q == 0) post_status(ST_OK, 16'd0);
				else begin
					i = -1;
					for (int k = SLOTS - 1; k >= 0; k--)
						if (!live[k]) i = k;
					if (i < 0) post_status(ST_REJECT, 16'd0);
					else begin
						rest_order(i, s, p, id, q);
						cross_book();
						post_status(ST_OK, 16'd0);
					end
				end
			end
			ACT_MARKET: begin
				arrivals++;
				left = q;
				while (left > 0) begin
					r = top_of(~s);
					if (r < 0) break;
					t = left < rest[r] ? left : rest[r];
					if (s == 1'b0) post_fill(id, oid[r], lvl[r], t);
					else post_fill(oid[r], id, lvl[r], t);
					left -= t;
					reduce(r, t);
				end
				if (left > 0) post_status(ST_PARTIAL, left);
				else post_status(ST_OK, 16'd0);
			end
			ACT_CANCEL: begin
				i = find_order(id);
				if (i < 0) post_status(ST_NOT_FOUND, 16'd0);
				else begin
					live[i] = 1'b0;
					post_status(ST_OK, 16'd0);
				end
			end
			default: begin
				i = find_order(id);
				if (i < 0) post_status(ST_NOT_FOUND, 16'd0);
				else begin
					if (q == 0) live[i] = 1'b0;
					else if (lvl[i] != p) begin
						rest_order(i, sd[i], p, id, q);
						cross_book();
					end else begin
						// raising quantity loses time priority
						if (q > rest[i]) begin
							stamp[i] = arrivals;
							arrivals++;
						end
						rest[i] = q;
						cross_book();
					end
					post_status(ST_OK, 16'd0);
				end
			end
		endcase
	endtask

	assign pending = wr_idx - rd_idx;

	// Predict on each request beat, compare each result beat
	always @(posedge clk or negedge arst_n) begin
		fill_t want, got;
		if (!arst_n) begin
			for (int i = 0; i < SLOTS; i++) live[i] = 1'b0;
			arrivals = 0;
			wr_idx = 0;
			rd_idx = 0;
			errors = 0;
		end else begin
			if (m_tvalid && m_tready) begin
				got = {m_tuser, m_tdata[15:0], m_tdata[31:16], m_tdata[39:32],
					m_tdata[55:40], m_tdata[57:56], m_tdata[73:58], m_tlast};
				if (wr_idx == rd_idx) begin
					errors++;
					if (errors <= 10) $display("unexpected result beat %h", got);
				end else begin
					want = due_q[rd_idx & 63];
					rd_idx++;
					if (got !== want || m_tdata[79:74] !== 6'd0) begin
						errors++;
						if (errors <= 10)
							$display("result mismatch: expected %h, got %h", want, got);
					end
				end
			end
			if (s_tvalid && s_tready) apply_request(s_tuser, s_tdata);
		end
	end
endmodule
`default_nettype wire

// ===== sim/tb_limit_order_book_matcher.sv =====
// Testbench top for the order book matcher: stimulus, reset, clock and verdict.
`default_nettype none
module tb_limit_order_book_matcher;
	import lobm_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [47:0] s_tdata;
	logic [1:0]  s_tuser;
	logic        m_tvalid;
	logic        m_tready;
	logic [79:0] m_tdata;
	logic        m_tuser;
	logic        m_tlast;
	int          errors;
	int          pending;
	int          cycles;
	bit          calm;

	limit_order_book_matcher dut (
		.clk, .arst_n, .s_tvalid, .s_tready, .s_tdata, .s_tuser,
		.m_tvalid, .m_tready, .m_tdata, .m_tuser, .m_tlast
	);

	lobm_scoreboard chk (
		.clk, .arst_n, .s_tvalid, .s_tready, .s_tdata, .s_tuser,
		.m_tvalid, .m_tready, .m_tdata, .m_tuser, .m_tlast, .errors, .pending
	);

	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	// Timeout watchdog
	always @(posedge clk) begin
		cycles++;
		if (cycles > 2000000) begin
			$display("[limit_order_book_matcher] ERROR");
			$finish;
		end
	end

	// Random stalls on the result side
	initial begin
		m_tready = 1'b0;
		@(negedge clk);
		forever begin
			m_tready <= 1'b1;
			repeat ($urandom_range(1, 12)) @(negedge clk);
			if (!calm && $urandom_range(0, 2) == 0) begin
				m_tready <= 1'b0;
				repeat ($urandom_range(1, 7)) @(negedge clk);
			end
		end
	end

	// Drive one request beat; valid stays up until the next beat or idle burst
	task automatic send(logic [1:0] act, logic [15:0] id, logic s, logic [7:0] p,
			logic [15:0] q);
		if (!calm && $urandom_range(0, 3) == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 7)) @(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= act;
		s_tdata <= {7'd0, q, p, s, id};
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		@(negedge clk);
	endtask

	initial begin
		logic [1:0]  act;
		logic [15:0] q;
		cycles = 0;
		calm = 1'b0;
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = ACT_LIMIT;
		repeat (6) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Directed: reject, fills, price-time priority, modifies, extremes
		send(ACT_CANCEL, 16'd5, 1'b0, 8'd0, 16'd1);
		send(ACT_MODIFY, 16'hFFFF, 1'b0, 8'd0, 16'd1);
		send(ACT_LIMIT, 16'd1, 1'b0, 8'd100, 16'd10);
		send(ACT_LIMIT, 16'd1, 1'b1, 8'd90, 16'd10);
		send(ACT_LIMIT, 16'd2, 1'b0, 8'd100, 16'd0);
		send(ACT_LIMIT, 16'd3, 1'b0, 8'd100, 16'd5);
		send(ACT_LIMIT, 16'd4, 1'b1, 8'd99, 16'd12);
		send(ACT_LIMIT, 16'd0, 1'b1, 8'd255, 16'hFFFF);
		send(ACT_LIMIT, 16'hFFFF, 1'b0, 8'd0, 16'hFFFF);
		send(ACT_MODIFY, 16'hFFFF, 1'b0, 8'd0, 16'd3);
		send(ACT_MODIFY, 16'd0, 1'b0, 8'd255, 16'd100);
		send(ACT_MODIFY, 16'd0, 1'b0, 8'd255, 16'd50);
		send(ACT_MARKET, 16'd9, 1'b0, 8'd0, 16'd60);
		send(ACT_MARKET, 16'd8, 1'b1, 8'd0, 16'd0);
		send(ACT_MARKET, 16'hFFFF, 1'b1, 8'd7, 16'hFFFF);
		send(ACT_MODIFY, 16'd0, 1'b0, 8'd1, 16'd0);
		send(ACT_CANCEL, 16'd0, 1'b0, 8'd0, 16'd0);
		send(ACT_CANCEL, 16'hFFFF, 1'b0, 8'd0, 16'd0);
		// Fill the book to reject on full
		for (int i = 0; i < 33; i++) send(ACT_LIMIT, 16'(100 + i), 1'b1, 8'd200, 16'd1);
		send(ACT_MARKET, 16'd7, 1'b0, 8'd0, 16'd40);

		// Random: small id pool so cancels and modifies hit resting orders
		for (int n = 0; n < 150; n++) begin
			if (n == 130) calm = 1'b1;
			act = 2'($urandom_range(0, 9) < 5 ? ACT_LIMIT :
				$urandom_range(ACT_MARKET, ACT_MODIFY));
			q = $urandom_range(0, 15) == 0 ? 16'($urandom) : 16'($urandom_range(0, 40));
			send(act, $urandom_range(0, 9) == 0 ? 16'($urandom) : 16'($urandom_range(0, 40)),
				1'($urandom), 8'($urandom_range(0, 9) == 0 ? $urandom : $urandom_range(95, 105)),
				q);
		end
		s_tvalid <= 1'b0;

		while (pending != 0) @(posedge clk);
		repeat (100) @(posedge clk);
		if (errors == 0 && pending == 0) begin
			$display("[limit_order_book_matcher] OK");
		end else begin
			$display("[limit_order_book_matcher] ERROR");
		end
		$finish;
	end
endmodule
`default_nettype wire

// ===== files.f =====
src/lobm_pkg.sv
src/lobm_cell.sv
src/limit_order_book_matcher.sv
src/lobm_checker.sv
sim/lobm_checker.sv
sim/tb_limit_order_book_matcher.sv
